// ===== hdl/ppp_pkg.sv =====
// Shared types, widths and codes of the pinhole point projection block.
`default_nettype none
package ppp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // magnitude bits of a divider operand, signed operand width
  localparam int MAG_W   = 36;
  localparam int COORD_W = MAG_W + 1;
  // magnitude of a quotient after the zero-divisor clamp
  localparam int QMAG_W  = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    CMD_WORLD = 2'd0,
    CMD_LOCAL = 2'd1,
    CMD_DEPTH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_ROT0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TXY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TZ    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_USE_T = 3'd7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] z;
  } div_sb_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       dz;
  } mul_sb_t;

endpackage
`default_nettype wire

// ===== hdl/ppp_div.sv =====
// Pipelined signed fixed-point divider, one quotient bit per stage.
`default_nettype none
module ppp_div import ppp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic signed [COORD_W-1:0] num_i,
  input  wire logic signed [COORD_W-1:0] den_i,
  output logic [QMAG_W-1:0]              q_mag_o,
  output logic                           q_neg_o,
  output logic                           dz_o
);

  localparam int NW = MAG_W + FRAC_BITS;
  localparam logic [QMAG_W-1:0] LIM = QMAG_W'(1) << (QMAG_W - 1);

  logic [NW-1:0]    nq_q   [NW+1];
  logic [MAG_W-1:0] rem_q  [NW+1];
  logic [MAG_W-1:0] dmag_q [NW+1];
  logic             neg_q  [NW+1];
  logic             dz_q   [NW+1];
  logic             nz_q   [NW+1];

  logic [COORD_W-1:0] nabs, dabs;

  assign nabs = num_i[COORD_W-1] ? COORD_W'(-num_i) : COORD_W'(num_i);
  assign dabs = den_i[COORD_W-1] ? COORD_W'(-den_i) : COORD_W'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]   <= {nabs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      rem_q[0]  <= '0;
      dmag_q[0] <= dabs[MAG_W-1:0];
      dz_q[0]   <= (den_i == '0);
      nz_q[0]   <= (num_i != '0);
      neg_q[0]  <= (den_i == '0) ? num_i[COORD_W-1] : (num_i[COORD_W-1] ^ den_i[COORD_W-1]);
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [MAG_W:0] trial, diff;
    logic           ge;
    assign trial = {rem_q[k-1], nq_q[k-1][NW-1]};
    assign diff  = trial - {1'b0, dmag_q[k-1]};
    assign ge    = (trial >= {1'b0, dmag_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        nq_q[k]   <= {nq_q[k-1][NW-2:0], ge};
        dmag_q[k] <= dmag_q[k-1];
        dz_q[k]   <= dz_q[k-1];
        nz_q[k]   <= nz_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
  end

  always_comb begin
    if (dz_q[NW]) begin
      q_mag_o = nz_q[NW] ? LIM : '0;
    end else begin
      q_mag_o = QMAG_W'(nq_q[NW]);
    end
  end

  assign q_neg_o = neg_q[NW];
  assign dz_o    = dz_q[NW];

endmodule
`default_nettype wire

// ===== hdl/ppp_mul.sv =====
// Two-stage fixed-point multiplier with truncated magnitude and clamp.
`default_nettype none
module ppp_mul import ppp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [QMAG_W-1:0]        a_mag_i,
  input  wire logic                     a_neg_i,
  input  wire logic signed [31:0]       b_i,
  output logic signed [63:0]            p_o
);

  localparam int PW = QMAG_W + 32;
  localparam int SW = PW - FRAC_BITS;
  localparam logic [SW-1:0] LIM = SW'(1) << (QMAG_W - 1);

  logic [31:0]        bmag;
  logic [63:0]        plo_q;
  logic [QMAG_W-33:0] ahi;
  logic [PW-33:0]     phi_q;
  logic               neg_q;
  logic [PW-1:0]      prod;
  logic [SW-1:0]      ps;
  logic [QMAG_W-1:0]  mag;
  logic signed [63:0] p_q;

  assign bmag = b_i[31] ? 32'(-b_i) : 32'(b_i);
  assign ahi  = a_mag_i[QMAG_W-1:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= 64'(a_mag_i[31:0]) * 64'(bmag);
      phi_q <= (PW-32)'(ahi) * (PW-32)'(bmag);
      neg_q <= a_neg_i ^ b_i[31];
    end
  end

  assign prod = {phi_q, 32'b0} + PW'(plo_q);
  assign ps   = prod[PW-1:FRAC_BITS];
  assign mag  = (ps > LIM) ? LIM[QMAG_W-1:0] : ps[QMAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== hdl/pinhole_point_projection.sv =====
// Top level of the pinhole camera point projection pipeline.
// Maps one point per cycle while the output is not stalled: command world-to-image
// (optional translation and transposed rotation, then projection), local-to-image,
// or image-plus-depth to local. The pipeline holds three front stages, the
// divider's operand register and FRAC_BITS + 36 restoring divider stages that
// resolve one quotient bit each, two multiplier stages and the output register.
// A stalled output freezes the whole pipeline; nothing is lost.
// Configuration registers are read live and must be written only while idle.
`default_nettype none
module pinhole_point_projection import ppp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o
);

  localparam int NW      = MAG_W + FRAC_BITS;
  localparam int DIV_LAT = NW + 1;
  localparam int MUL_LAT = 2;

  // configuration
  logic [47:0] rot_q [3];
  logic [63:0] txy_q, focal_q, pp_q;
  logic [31:0] tz_q;
  logic        use_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= 48'h0000_0000_4000;
      rot_q[1] <= 48'h0000_4000_0000;
      rot_q[2] <= 48'h4000_0000_0000;
      txy_q    <= '0;
      tz_q     <= '0;
      focal_q  <= {32'(1) << FRAC_BITS, 32'(1) << FRAC_BITS};
      pp_q     <= '0;
      use_t_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROT0:  rot_q[0] <= cfg_data_i[47:0];
        REG_ROT1:  rot_q[1] <= cfg_data_i[47:0];
        REG_ROT2:  rot_q[2] <= cfg_data_i[47:0];
        REG_TXY:   txy_q    <= cfg_data_i;
        REG_TZ:    tz_q     <= cfg_data_i[31:0];
        REG_FOCAL: focal_q  <= cfg_data_i;
        REG_PP:    pp_q     <= cfg_data_i;
        REG_USE_T: use_t_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] fu, fv, u0, v0;
  assign fu = $signed(focal_q[31:0]);
  assign fv = $signed(focal_q[63:32]);
  assign u0 = $signed(pp_q[31:0]);
  assign v0 = $signed(pp_q[63:32]);

  logic en;
  logic out_valid_q;
  out_t out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: differences
  logic               v1_q;
  logic [1:0]         cmd1_q;
  logic signed [31:0] a1_q, b1_q, z1_q;
  logic signed [32:0] d1_q [3];
  logic signed [32:0] na1_q, nb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= in_data_i.cmd;
      a1_q    <= in_data_i.coord_a;
      b1_q    <= in_data_i.coord_b;
      z1_q    <= in_data_i.coord_z;
      d1_q[0] <= 33'(in_data_i.coord_a) - 33'($signed(txy_q[31:0]));
      d1_q[1] <= 33'(in_data_i.coord_b) - 33'($signed(txy_q[63:32]));
      d1_q[2] <= 33'(in_data_i.coord_z) - 33'($signed(tz_q));
      na1_q   <= 33'(in_data_i.coord_a) - 33'(u0);
      nb1_q   <= 33'(v0) - 33'(in_data_i.coord_b);
    end
  end

  // stage 2: rotation products, p2_q[i][j] = R[j][i] * d[j]
  logic               v2_q;
  logic [1:0]         cmd2_q;
  logic signed [31:0] a2_q, b2_q, z2_q;
  logic signed [32:0] na2_q, nb2_q;
  logic signed [48:0] p2_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd2_q <= cmd1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      z2_q   <= z1_q;
      na2_q  <= na1_q;
      nb2_q  <= nb1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2_q[i][j] <= 49'($signed(rot_q[j][16*i +: 16])) * 49'(d1_q[j]);
        end
      end
    end
  end

  // stage 3: sums, rounding and divider operand selection
  logic signed [50:0]        s3 [3];
  logic signed [50:0]        r3 [3];
  logic signed [COORD_W-1:0] q3 [3];
  logic                      xf3;
  logic signed [COORD_W-1:0] nx3, ny3, dx3, dy3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3[i] = 51'(p2_q[i][0]) + 51'(p2_q[i][1]) + 51'(p2_q[i][2]) + 51'sd8192;
      r3[i] = s3[i] >>> 14;
      q3[i] = r3[i][COORD_W-1:0];
    end
    xf3 = (cmd2_q == CMD_WORLD) && use_t_q;
    if (cmd2_q == CMD_DEPTH) begin
      nx3 = COORD_W'(na2_q);
      ny3 = COORD_W'(nb2_q);
      dx3 = COORD_W'(fu);
      dy3 = COORD_W'(fv);
    end else if (xf3) begin
      nx3 = q3[0];
      ny3 = q3[1];
      dx3 = q3[2];
      dy3 = q3[2];
    end else begin
      nx3 = COORD_W'(a2_q);
      ny3 = COORD_W'(b2_q);
      dx3 = COORD_W'(z2_q);
      dy3 = COORD_W'(z2_q);
    end
  end

  logic                      v3_q;
  div_sb_t                   sb3_q;
  logic signed [COORD_W-1:0] nx_q, ny_q, dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb3_q.cmd <= cmd2_q;
      sb3_q.z   <= z2_q;
      nx_q      <= nx3;
      ny_q      <= ny3;
      dx_q      <= dx3;
      dy_q      <= dy3;
    end
  end

  // divider stages
  logic [QMAG_W-1:0] qx_mag, qy_mag;
  logic              qx_neg, qy_neg, dzx, dzy;

  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (nx_q),
    .den_i   (dx_q),
    .q_mag_o (qx_mag),
    .q_neg_o (qx_neg),
    .dz_o    (dzx)
  );

  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (ny_q),
    .den_i   (dy_q),
    .q_mag_o (qy_mag),
    .q_neg_o (qy_neg),
    .dz_o    (dzy)
  );

  logic [DIV_LAT-1:0] dv_q;
  div_sb_t            dsb_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[DIV_LAT-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsb_q[0] <= sb3_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        dsb_q[k] <= dsb_q[k-1];
      end
    end
  end

  // multiplier stages
  div_sb_t            dsb_last;
  logic signed [31:0] gx, gy;
  logic signed [63:0] px, py;

  assign dsb_last = dsb_q[DIV_LAT-1];
  assign gx = (dsb_last.cmd == CMD_DEPTH) ? dsb_last.z : fu;
  assign gy = (dsb_last.cmd == CMD_DEPTH) ? dsb_last.z : fv;

  ppp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_mag_i (qx_mag),
    .a_neg_i (qx_neg),
    .b_i     (gx),
    .p_o     (px)
  );

  ppp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_mag_i (qy_mag),
    .a_neg_i (qy_neg),
    .b_i     (gy),
    .p_o     (py)
  );

  logic [MUL_LAT-1:0] mv_q;
  mul_sb_t            msb_q [MUL_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= '0;
    end else if (en) begin
      mv_q <= {mv_q[MUL_LAT-2:0], dv_q[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msb_q[0].cmd <= dsb_last.cmd;
      msb_q[0].dz  <= dzx | dzy;
      for (int k = 1; k < MUL_LAT; k++) begin
        msb_q[k] <= msb_q[k-1];
      end
    end
  end

  // final offsets, saturation and status
  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

  mul_sb_t            msb_last;
  logic signed [64:0] ea, eb;
  logic               sat_a, sat_b, known;
  out_t               out_d;

  assign msb_last = msb_q[MUL_LAT-1];

  always_comb begin
    known = 1'b1;
    case (msb_last.cmd) inside
      CMD_WORLD, CMD_LOCAL: begin
        ea = 65'(px) + 65'(u0);
        eb = 65'(v0) - 65'(py);
      end
      CMD_DEPTH: begin
        ea = 65'(px);
        eb = 65'(py);
      end
      default: begin
        ea    = '0;
        eb    = '0;
        known = 1'b0;
      end
    endcase
    sat_a = (ea > SAT_HI) || (ea < SAT_LO);
    sat_b = (eb > SAT_HI) || (eb < SAT_LO);
    out_d.result_a = sat_a ? (ea[64] ? 32'sh8000_0000 : 32'sh7fff_ffff) : ea[31:0];
    out_d.result_b = sat_b ? (eb[64] ? 32'sh8000_0000 : 32'sh7fff_ffff) : eb[31:0];
    if (known && msb_last.dz) begin
      out_d.status = ST_DIVZ;
    end else if (sat_a || sat_b) begin
      out_d.status = ST_SAT;
    end else begin
      out_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mv_q[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("pipeline stalled without output backpressure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.status == ST_DIVZ ||
                     out_data_o.status == ST_SAT))
    else $error("status code out of range");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_SAT) |->
      (out_data_o.result_a == 32'sh7fff_ffff || out_data_o.result_a == 32'sh8000_0000 ||
       out_data_o.result_b == 32'sh7fff_ffff || out_data_o.result_b == 32'sh8000_0000))
    else $error("saturation status without a clamped result");

  a_valid_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && mv_q[MUL_LAT-1]) |=> out_valid_o)
    else $error("word lost at the output register");

endmodule
`default_nettype wire

// ===== sim/ppp_checker.sv =====
// Checker for the pinhole point projection block: predicts each result and compares.
`default_nettype none
module ppp_checker import ppp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire in_t                   in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire out_t                  out_data_i,
  output int                         errors_o,
  output int                         pending_o
);

  localparam int FB = FRAC_BITS_DEF;
  localparam longint LIM = 64'sh4000_0000_0000_0000;

  logic [47:0] rot_rows [3];
  logic [63:0] trans_xy, focal, pp;
  logic [31:0] trans_z;
  logic        use_t;
  out_t        expected_pts [$];

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [63:0] umag(longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint signed_clamp(logic [127:0] mag, logic neg);
    longint m;
    m = (mag > 128'(LIM)) ? LIM : longint'(mag[63:0]);
    return neg ? -m : m;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = 128'(umag(a)) * 128'(umag(b));
    return signed_clamp(p >> FB, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint n, longint d, inout logic zero);
    if (d == 0) begin
      zero = 1'b1;
      return (n > 0) ? LIM : ((n < 0) ? -LIM : 0);
    end
    return signed_clamp((128'(umag(n)) << FB) / 128'(umag(d)), (n < 0) != (d < 0));
  endfunction

  function automatic longint sat32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_t project_point(in_t pt);
    longint a, b, z, fu, fv, u0, v0, ra, rb, rx, ry, s;
    longint d [3];
    longint q [3];
    logic zero, sat;
    out_t r;
    a = sx32(pt.coord_a);
    b = sx32(pt.coord_b);
    z = sx32(pt.coord_z);
    fu = sx32(focal[31:0]);
    fv = sx32(focal[63:32]);
    u0 = sx32(pp[31:0]);
    v0 = sx32(pp[63:32]);
    ra = 0;
    rb = 0;
    zero = 1'b0;
    sat = 1'b0;
    if (pt.cmd == CMD_WORLD && use_t) begin
      d[0] = a - sx32(trans_xy[31:0]);
      d[1] = b - sx32(trans_xy[63:32]);
      d[2] = z - sx32(trans_z);
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += sx16(rot_rows[j][16*i +: 16]) * d[j];
        q[i] = (s + 8192) >>> 14;
      end
      a = q[0];
      b = q[1];
      z = q[2];
    end
    if (pt.cmd == CMD_WORLD || pt.cmd == CMD_LOCAL) begin
      rx = fx_div(a, z, zero);
      ry = fx_div(b, z, zero);
      ra = sat32(fx_mul(rx, fu) + u0, sat);
      rb = sat32(v0 - fx_mul(ry, fv), sat);
    end else if (pt.cmd == CMD_DEPTH) begin
      rx = fx_div(a - u0, fu, zero);
      ry = fx_div(v0 - b, fv, zero);
      ra = sat32(fx_mul(rx, z), sat);
      rb = sat32(fx_mul(ry, z), sat);
    end
    r.result_a = ra[31:0];
    r.result_b = rb[31:0];
    r.status = zero ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      rot_rows[0] <= 48'h0000_0000_4000;
      rot_rows[1] <= 48'h0000_4000_0000;
      rot_rows[2] <= 48'h4000_0000_0000;
      trans_xy <= '0;
      trans_z <= '0;
      focal <= {32'h0001_0000, 32'h0001_0000};
      pp <= '0;
      use_t <= 1'b0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROT0:  rot_rows[0] <= cfg_data_i[47:0];
          REG_ROT1:  rot_rows[1] <= cfg_data_i[47:0];
          REG_ROT2:  rot_rows[2] <= cfg_data_i[47:0];
          REG_TXY:   trans_xy <= cfg_data_i;
          REG_TZ:    trans_z <= cfg_data_i[31:0];
          REG_FOCAL: focal <= cfg_data_i;
          REG_PP:    pp <= cfg_data_i;
          REG_USE_T: use_t <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_pts.push_back(project_point(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_pts.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          exp_r = expected_pts.pop_front();
          if (out_data_i.result_a !== exp_r.result_a)
            report($sformatf("result_a %h, want %h", out_data_i.result_a, exp_r.result_a));
          if (out_data_i.result_b !== exp_r.result_b)
            report($sformatf("result_b %h, want %h", out_data_i.result_b, exp_r.result_b));
          if (out_data_i.status !== exp_r.status)
            report($sformatf("status %0d, want %0d", out_data_i.status, exp_r.status));
        end
      end
      pending_o <= expected_pts.size();
    end
  end

endmodule
`default_nettype wire

// ===== sim/pinhole_point_projection_tb.sv =====
// Testbench top for the pinhole point projection block: stimulus, idling and verdict.
`default_nettype none
module pinhole_point_projection_tb;
  import ppp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  int                    errors, pending;
  int                    burst_left = 0;
  int                    idle_cycles = 0;
  int                    stall_mode = 0;
  int                    stall_count = 0;

  pinhole_point_projection DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  ppp_checker checker_u (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver: randomly chosen stall pattern, chosen anew as stall_count advances
  always @(posedge clk_i) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= ((stall_count % 16) < 4);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(in_t pt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data <= pt;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
  endtask

  task automatic send_fields(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
                             logic [31:0] z);
    in_t pt;
    pt.cmd = cmd;
    pt.coord_a = a;
    pt.coord_b = b;
    pt.coord_z = z;
    send_point(pt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_small();
    return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  function automatic logic [31:0] rand_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(int count);
    logic [1:0] cmd;
    logic [31:0] z;
    repeat (count) begin
      cmd = 2'($urandom_range(0, 2));
      z = 32'($urandom_range(32'h0000_4000, 32'h0040_0000));
      if ($urandom_range(0, 1)) z = -z;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_fields(cmd, rand_small(), rand_small(), z);
        6: send_fields(2'($urandom()), $urandom(), $urandom(), $urandom());
        7: send_fields(cmd, rand_small(), rand_small(), 32'h0);
        8: send_fields(2'($urandom()), rand_extreme(), rand_extreme(), rand_extreme());
        default: send_fields(cmd, $urandom(), $urandom(), z);
      endcase
    end
  endtask

  function automatic logic [63:0] rand_rot_row();
    return {16'h0, 16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings: directed extremes and special cases, then random points
    send_fields(CMD_LOCAL, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_fields(CMD_WORLD, 32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000);
    send_fields(CMD_DEPTH, 32'h0004_0000, 32'h0005_0000, 32'h0002_0000);
    send_fields(CMD_LOCAL, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    send_fields(CMD_LOCAL, 32'h0, 32'h0, 32'h0);
    send_fields(CMD_WORLD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_fields(CMD_LOCAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_fields(CMD_LOCAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fields(CMD_LOCAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_fields(CMD_LOCAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fields(CMD_DEPTH, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(CMD_DEPTH, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_fields(CMD_DEPTH, 32'h0, 32'h0, 32'h0);
    send_fields(2'd3, 32'h1234_5678, 32'h8765_4321, 32'h0001_0000);
    send_fields(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(250);
    drain();

    // translation with identity rotation, offset principal point
    write_reg(REG_TXY, {32'h0002_0000, 32'hFFFF_0000});
    write_reg(REG_TZ, 64'hFFFF_FFFF_FFFF_8000);
    write_reg(REG_PP, {32'h00F0_0000, 32'h0140_0000});
    write_reg(REG_FOCAL, {32'h0200_0000, 32'h01F0_0000});
    write_reg(REG_USE_T, 64'h1);
    end_writes();
    send_fields(CMD_WORLD, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_8000);
    send_fields(CMD_DEPTH, 32'h00F0_0000, 32'h0140_0000, 32'h0003_0000);
    send_random(300);
    drain();

    // random rotation, translation, focal lengths and principal point
    write_reg(REG_ROT0, rand_rot_row());
    write_reg(REG_ROT1, rand_rot_row());
    write_reg(REG_ROT2, rand_rot_row());
    write_reg(REG_TXY, {$urandom(), $urandom()});
    write_reg(REG_TZ, {$urandom(), $urandom()});
    write_reg(REG_FOCAL, {16'h0, 16'($urandom()), 16'h0, 16'($urandom())});
    write_reg(REG_PP, {$urandom(), $urandom()});
    end_writes();
    send_random(300);
    drain();

    // extreme settings: full rotation entries, zero and extreme gains
    write_reg(REG_ROT0, 64'hFFFF_7FFF_7FFF_7FFF);
    write_reg(REG_ROT1, 64'h0000_8000_8000_8000);
    write_reg(REG_ROT2, 64'h0000_7FFF_8000_FFFF);
    write_reg(REG_TXY, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(REG_TZ, 64'h0000_0000_8000_0000);
    write_reg(REG_FOCAL, {32'h7FFF_FFFF, 32'h0});
    write_reg(REG_PP, {32'h7FFF_FFFF, 32'h8000_0000});
    end_writes();
    send_random(300);
    drain();

    // negative gains, transform off, extreme rotation left in place
    write_reg(REG_FOCAL, {32'h8000_0000, 32'hFFFF_0000});
    write_reg(REG_PP, 64'h0);
    write_reg(REG_USE_T, 64'hFFFF_FFFF_FFFF_FFFE);
    end_writes();
    send_random(300);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/ppp_pkg.sv
hdl/ppp_div.sv
hdl/ppp_mul.sv
hdl/pinhole_point_projection.sv
sim/ppp_checker.sv
sim/pinhole_point_projection_tb.sv
